>>> rtl/core/sexpr_pkg.sv
package sexpr_pkg;

	// Lexer modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_ATOM    = 3'd1;
	localparam logic [2:0] MODE_STR     = 3'd2;
	localparam logic [2:0] MODE_STRBS   = 3'd3;
	localparam logic [2:0] MODE_COMMA   = 3'd4;
	localparam logic [2:0] MODE_COMMENT = 3'd5;
	localparam logic [2:0] MODE_DISCARD = 3'd6;

	// Token kinds
	localparam logic [3:0] KIND_ATOM    = 4'd0;
	localparam logic [3:0] KIND_STRING  = 4'd1;
	localparam logic [3:0] KIND_OPEN    = 4'd2;
	localparam logic [3:0] KIND_CLOSE   = 4'd3;
	localparam logic [3:0] KIND_QUOTE   = 4'd4;
	localparam logic [3:0] KIND_QUASI   = 4'd5;
	localparam logic [3:0] KIND_UNQUOTE = 4'd6;
	localparam logic [3:0] KIND_SPLICE  = 4'd7;
	localparam logic [3:0] KIND_DOT     = 4'd8;

	// Characters with a special role
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BTICK  = 8'h60;

	localparam int unsigned MAX_RES = 4;

	typedef struct packed {
		logic [7:0] tchar;
		logic [3:0] kind;
		logic       first;
		logic       last;
		logic       err;
		logic       run_last;
	} token_t;

	typedef struct packed {
		token_t [MAX_RES-1:0] res;
		logic   [2:0]         cnt;
	} res_set_t;

endpackage

>>> rtl/core/sexpr_tokenizer_unit.sv
// S-expression tokenizer. Source bytes enter on the text channel, one per
// request, with line_end set on the last byte of each line; tokens leave on
// the token channel one byte per request, with first/last marks, the token
// kind, and last_of_run on the final result caused by each input byte. A byte
// passes from the input register to the result queue once the queue has room,
// and its results are offered from there. The block takes one byte per cycle
// as long as each byte yields at most one result and the token side does not
// stall; a byte that yields several results keeps the queue until its last
// result leaves and stalls the input meanwhile, since the result queue hands
// out one result per cycle. Bytes that yield nothing still pass through the
// input register.
module sexpr_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       line_end,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [7:0] token_char,
	output logic [3:0] token_kind,
	output logic       token_first,
	output logic       token_last,
	output logic       open_string_error,
	output logic       last_of_run
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eol_s1;
	logic                room;
	logic                advance;
	sexpr_pkg::res_set_t rset;

	assign advance    = valid_s1 && room;
	assign text_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= text_byte;
			eol_s1  <= line_end;
		end
	end

	sexpr_lex_core u_lex (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.eol_s1  (eol_s1),
		.advance (advance),
		.rset    (rset)
	);

	sexpr_result_buf u_buf (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (advance),
		.rset              (rset),
		.room              (room),
		.token_valid       (token_valid),
		.token_stall       (token_stall),
		.token_char        (token_char),
		.token_kind        (token_kind),
		.token_first       (token_first),
		.token_last        (token_last),
		.open_string_error (open_string_error),
		.last_of_run       (last_of_run)
	);

endmodule

>>> rtl/core/sexpr_lex_core.sv
module sexpr_lex_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_s1,
	input  logic                eol_s1,
	input  logic                advance,
	output sexpr_pkg::res_set_t rset
);

	typedef struct packed {
		logic [2:0]                     mode;
		logic [7:0]                     hchar;
		logic                           hvalid;
		logic [3:0]                     hkind;
		logic                           hfirst;
		sexpr_pkg::token_t [3:0]        res;
		logic [2:0]                     cnt;
	} ctx_t;

	logic [2:0] mode_q;
	logic [7:0] held_char_q;
	logic       held_valid_q;
	logic [3:0] held_kind_q;
	logic       held_first_q;
	ctx_t       nxt;

	function automatic logic is_space(input logic [7:0] ch);
		return ch == sexpr_pkg::CH_SPACE || ch == sexpr_pkg::CH_TAB ||
			ch == sexpr_pkg::CH_LF || ch == sexpr_pkg::CH_CR;
	endfunction

	function automatic logic is_delim(input logic [7:0] ch);
		return is_space(ch) || ch == sexpr_pkg::CH_LPAREN || ch == sexpr_pkg::CH_RPAREN ||
			ch == sexpr_pkg::CH_DQUOTE || ch == sexpr_pkg::CH_SQUOTE ||
			ch == sexpr_pkg::CH_BTICK || ch == sexpr_pkg::CH_COMMA ||
			ch == sexpr_pkg::CH_SEMI;
	endfunction

	function automatic ctx_t emit(input ctx_t c, input logic [7:0] ch, input logic [3:0] k,
			input logic f, input logic l, input logic e);
		ctx_t r;
		r = c;
		// drop anything past the result limit
		if (c.cnt < 3'(sexpr_pkg::MAX_RES)) begin
			r.res[c.cnt[1:0]].tchar    = ch;
			r.res[c.cnt[1:0]].kind     = k;
			r.res[c.cnt[1:0]].first    = f;
			r.res[c.cnt[1:0]].last     = l;
			r.res[c.cnt[1:0]].err      = e;
			r.res[c.cnt[1:0]].run_last = 1'b0;
			r.cnt = c.cnt + 3'd1;
		end
		return r;
	endfunction

	function automatic ctx_t push(input ctx_t c, input logic [7:0] ch, input logic [3:0] k,
			input logic f);
		ctx_t r;
		r = c;
		if (c.hvalid)
			r = emit(r, c.hchar, c.hkind, c.hfirst, 1'b0, 1'b0);
		r.hchar  = ch;
		r.hkind  = k;
		r.hfirst = f;
		r.hvalid = 1'b1;
		return r;
	endfunction

	function automatic ctx_t finish(input ctx_t c, input logic e);
		ctx_t r;
		r = c;
		if (c.hvalid)
			r = emit(r, c.hchar, c.hkind, c.hfirst, 1'b1, e);
		r.hvalid = 1'b0;
		r.hfirst = 1'b0;
		return r;
	endfunction

	function automatic ctx_t lex_idle(input ctx_t c, input logic [7:0] ch);
		ctx_t r;
		r = c;
		if (is_space(ch)) begin
			r = c;
		end else if (ch == sexpr_pkg::CH_SEMI) begin
			r.mode = sexpr_pkg::MODE_COMMENT;
		end else if (ch == sexpr_pkg::CH_COMMA) begin
			r = push(r, ch, sexpr_pkg::KIND_UNQUOTE, 1'b1);
			r.mode = sexpr_pkg::MODE_COMMA;
		end else if (ch == sexpr_pkg::CH_LPAREN) begin
			r = emit(r, ch, sexpr_pkg::KIND_OPEN, 1'b1, 1'b1, 1'b0);
		end else if (ch == sexpr_pkg::CH_RPAREN) begin
			r = emit(r, ch, sexpr_pkg::KIND_CLOSE, 1'b1, 1'b1, 1'b0);
		end else if (ch == sexpr_pkg::CH_SQUOTE) begin
			r = emit(r, ch, sexpr_pkg::KIND_QUOTE, 1'b1, 1'b1, 1'b0);
		end else if (ch == sexpr_pkg::CH_BTICK) begin
			r = emit(r, ch, sexpr_pkg::KIND_QUASI, 1'b1, 1'b1, 1'b0);
		end else if (ch == sexpr_pkg::CH_DOT) begin
			r = emit(r, ch, sexpr_pkg::KIND_DOT, 1'b1, 1'b1, 1'b0);
		end else if (ch == sexpr_pkg::CH_DQUOTE) begin
			r = push(r, ch, sexpr_pkg::KIND_STRING, 1'b1);
			r.mode = sexpr_pkg::MODE_STR;
		end else begin
			r = push(r, ch, sexpr_pkg::KIND_ATOM, 1'b1);
			r.mode = sexpr_pkg::MODE_ATOM;
		end
		return r;
	endfunction

	function automatic ctx_t lex(input ctx_t c, input logic [7:0] ch);
		ctx_t r;
		r = c;
		unique case (c.mode)
			sexpr_pkg::MODE_IDLE: begin
				r = lex_idle(r, ch);
			end
			sexpr_pkg::MODE_ATOM: begin
				if (is_delim(ch)) begin
					r = finish(r, 1'b0);
					r.mode = sexpr_pkg::MODE_IDLE;
					r = lex_idle(r, ch);
				end else begin
					r = push(r, ch, sexpr_pkg::KIND_ATOM, 1'b0);
				end
			end
			sexpr_pkg::MODE_COMMA: begin
				if (ch == sexpr_pkg::CH_AT) begin
					// retag the held comma, then close the pair
					r.hkind = sexpr_pkg::KIND_SPLICE;
					r = push(r, ch, sexpr_pkg::KIND_SPLICE, 1'b0);
					r = finish(r, 1'b0);
					r.mode = sexpr_pkg::MODE_IDLE;
				end else begin
					r = finish(r, 1'b0);
					r.mode = sexpr_pkg::MODE_IDLE;
					r = lex_idle(r, ch);
				end
			end
			sexpr_pkg::MODE_STR: begin
				if (ch == sexpr_pkg::CH_DQUOTE) begin
					r = finish(r, 1'b0);
					r.mode = sexpr_pkg::MODE_IDLE;
				end else if (ch == sexpr_pkg::CH_BSLASH) begin
					r.mode = sexpr_pkg::MODE_STRBS;
				end else begin
					r = push(r, ch, sexpr_pkg::KIND_STRING, 1'b0);
				end
			end
			sexpr_pkg::MODE_STRBS: begin
				if (ch == sexpr_pkg::CH_DQUOTE) begin
					r = push(r, sexpr_pkg::CH_DQUOTE, sexpr_pkg::KIND_STRING, 1'b0);
					r.mode = sexpr_pkg::MODE_STR;
				end else if (ch == sexpr_pkg::CH_BSLASH) begin
					r = push(r, sexpr_pkg::CH_BSLASH, sexpr_pkg::KIND_STRING, 1'b0);
				end else begin
					r = push(r, sexpr_pkg::CH_BSLASH, sexpr_pkg::KIND_STRING, 1'b0);
					r = push(r, ch, sexpr_pkg::KIND_STRING, 1'b0);
					r.mode = sexpr_pkg::MODE_STR;
				end
			end
			sexpr_pkg::MODE_COMMENT: begin
				if (ch == sexpr_pkg::CH_LF)
					r.mode = sexpr_pkg::MODE_IDLE;
			end
			default: begin
				r = c;
			end
		endcase
		return r;
	endfunction

	function automatic ctx_t end_line(input ctx_t c);
		ctx_t r;
		r = lex(c, sexpr_pkg::CH_SPACE);
		if (r.mode inside {sexpr_pkg::MODE_STR, sexpr_pkg::MODE_STRBS}) begin
			r = finish(r, 1'b1);
			r.mode = sexpr_pkg::MODE_IDLE;
		end else if (r.mode == sexpr_pkg::MODE_COMMENT) begin
			r.mode = sexpr_pkg::MODE_IDLE;
		end
		return r;
	endfunction

	always_comb begin
		ctx_t c;
		c.mode   = (mode_q > sexpr_pkg::MODE_DISCARD) ? sexpr_pkg::MODE_IDLE : mode_q;
		c.hchar  = held_char_q;
		c.hvalid = held_valid_q;
		c.hkind  = held_kind_q;
		c.hfirst = held_first_q;
		c.res    = '0;
		c.cnt    = 3'd0;
		if (c.mode == sexpr_pkg::MODE_DISCARD) begin
			if (eol_s1)
				c.mode = sexpr_pkg::MODE_IDLE;
		end else if (byte_s1 == sexpr_pkg::CH_NUL) begin
			// NUL closes the line early; skip up to the flagged end
			c = end_line(c);
			c.mode = eol_s1 ? sexpr_pkg::MODE_IDLE : sexpr_pkg::MODE_DISCARD;
		end else begin
			c = lex(c, byte_s1);
			if (eol_s1)
				c = end_line(c);
		end
		for (int i = 0; i < sexpr_pkg::MAX_RES; i++) begin
			if (c.cnt == 3'(i + 1))
				c.res[i].run_last = 1'b1;
		end
		nxt = c;
	end

	assign rset.res = nxt.res;
	assign rset.cnt = nxt.cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= sexpr_pkg::MODE_IDLE;
			held_char_q  <= 8'd0;
			held_valid_q <= 1'b0;
			held_kind_q  <= 4'd0;
			held_first_q <= 1'b0;
		end else if (advance) begin
			mode_q       <= nxt.mode;
			held_char_q  <= nxt.hchar;
			held_valid_q <= nxt.hvalid;
			held_kind_q  <= nxt.hkind;
			held_first_q <= nxt.hfirst;
		end
	end

endmodule

>>> rtl/core/sexpr_result_buf.sv
module sexpr_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sexpr_pkg::res_set_t rset,
	output logic                room,
	output logic                token_valid,
	input  logic                token_stall,
	output logic [7:0]          token_char,
	output logic [3:0]          token_kind,
	output logic                token_first,
	output logic                token_last,
	output logic                open_string_error,
	output logic                last_of_run
);

	sexpr_pkg::token_t buf_q [sexpr_pkg::MAX_RES];
	logic [2:0]        cnt_q;
	logic              pop;

	assign token_valid = cnt_q != 3'd0;
	assign pop         = token_valid && !token_stall;
	// take a new set once the last pending result leaves
	assign room        = (cnt_q == 3'd0) || (cnt_q == 3'd1 && pop);

	assign token_char        = buf_q[0].tchar;
	assign token_kind        = buf_q[0].kind;
	assign token_first       = buf_q[0].first;
	assign token_last        = buf_q[0].last;
	assign open_string_error = buf_q[0].err;
	assign last_of_run       = buf_q[0].run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= rset.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < sexpr_pkg::MAX_RES; i++)
				buf_q[i] <= rset.res[i];
		end else if (pop) begin
			// advance the queue by one
			for (int i = 0; i < sexpr_pkg::MAX_RES - 1; i++)
				buf_q[i] <= buf_q[i+1];
		end
	end

endmodule

>>> rtl/core/sexpr_tokenizer_checker.sv
module sexpr_tokenizer_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_stall,
	input logic [7:0] text_byte,
	input logic       line_end,
	input logic       token_valid,
	input logic       token_stall,
	input logic [7:0] token_char,
	input logic [3:0] token_kind,
	input logic       token_first,
	input logic       token_last,
	input logic       open_string_error,
	input logic       last_of_run
);

	// a stalled text request holds
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> text_valid && $stable(text_byte) &&
		$stable(line_end))
		else $error("stalled text request changed");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_char) &&
		$stable(token_kind) && $stable(token_first) && $stable(token_last) &&
		$stable(last_of_run))
		else $error("stalled token changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == sexpr_pkg::KIND_OPEN ||
		token_kind == sexpr_pkg::KIND_CLOSE || token_kind == sexpr_pkg::KIND_QUOTE ||
		token_kind == sexpr_pkg::KIND_QUASI || token_kind == sexpr_pkg::KIND_DOT)
		|-> token_first && token_last)
		else $error("single-byte token not marked first and last");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && open_string_error |->
		token_kind == sexpr_pkg::KIND_STRING && token_last)
		else $error("open string error outside a closing string byte");

	a_splice: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == sexpr_pkg::KIND_SPLICE |->
		(token_first && !token_last && token_char == sexpr_pkg::CH_COMMA) ||
		(!token_first && token_last && token_char == sexpr_pkg::CH_AT))
		else $error("malformed splice token");

endmodule

bind sexpr_tokenizer_unit sexpr_tokenizer_checker u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.text_valid        (text_valid),
	.text_stall        (text_stall),
	.text_byte         (text_byte),
	.line_end          (line_end),
	.token_valid       (token_valid),
	.token_stall       (token_stall),
	.token_char        (token_char),
	.token_kind        (token_kind),
	.token_first       (token_first),
	.token_last        (token_last),
	.open_string_error (open_string_error),
	.last_of_run       (last_of_run)
);
